>>> sv/rpn_pkg.sv
// Shared types and constants for the reverse Polish calculator.
`default_nettype none
package rpn_pkg;

  localparam int unsigned StackDepth = 128;
  localparam int unsigned PtrW = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned ValW = 64;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [2:0] {
    FN_PUSH = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_MUL  = 3'd3,
    FN_DIV  = 3'd4,
    FN_REM  = 3'd5,
    FN_PRT  = 3'd6,
    FN_UNK  = 3'd7
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [ValW-1:0]   operand;
  } token_t;

  typedef struct packed {
    logic [ValW-1:0] printed_value;
    logic            printed_valid;
    logic            zero_divisor;
    logic            stack_empty;
    logic            stack_full;
    logic            unknown_command;
  } result_t;

  localparam logic [ValW-1:0] MinRaw = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] MaxRaw = {1'b0, {(ValW-1){1'b1}}};

endpackage
`default_nettype wire

>>> sv/rpn_stack_calculator_top.sv
// Top level of the reverse Polish calculator.
//
//   channel   direction  handshake      payload
//   token     in         push / full    func_i, operand_value_i
//   result    out        pop / empty    printed_*, flag outputs
//
// A token waits in the token queue, then passes through the engine states;
// divide and remainder run on the one-bit-per-cycle divider (96 and 64 steps).
// Reset clears the stack pointer and all queues; stack contents are not
// cleared. A two-entry token queue and a result register let either side stall
// on its own.
`default_nettype none
module rpn_stack_calculator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  func_i,
  input  wire logic signed [63:0] operand_value_i,
  output logic             empty,
  input  wire logic        pop,
  output logic signed [63:0] printed_value_o,
  output logic             printed_valid_o,
  output logic             zero_divisor_o,
  output logic             stack_empty_o,
  output logic             stack_full_o,
  output logic             unknown_command_o
);
  import rpn_pkg::*;

  token_t  tok_in, tok;
  logic    tok_valid, tok_take, res_valid;
  result_t res;

  assign tok_in.func    = func_e'(func_i);
  assign tok_in.operand = operand_value_i;

  rpn_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .tok_i       (tok_in),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_take_i  (tok_take)
  );

  rpn_back u_back (
    .clk_i, .rst_ni,
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_take_o  (tok_take),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (pop)
  );

  assign empty             = !res_valid;
  assign printed_value_o   = res.printed_value;
  assign printed_valid_o   = res.printed_valid;
  assign zero_divisor_o    = res.zero_divisor;
  assign stack_empty_o     = res.stack_empty;
  assign stack_full_o      = res.stack_full;
  assign unknown_command_o = res.unknown_command;
endmodule
`default_nettype wire

>>> sv/rpn_front.sv
// Token queue between the input port and the execution engine.
`default_nettype none
module rpn_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire rpn_pkg::token_t tok_i,
  output logic                 tok_valid_o,
  output rpn_pkg::token_t      tok_o,
  input  wire logic            tok_take_i
);
  import rpn_pkg::*;

  token_t     mem_q [FifoDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full        = (cnt_q == 2'(FifoDepth));
  assign do_wr       = push && !full;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign do_rd       = tok_take_i && tok_valid_o;
  assign tok_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule
`default_nettype wire

>>> sv/rpn_divider.sv
// Iterative restoring divider, one quotient bit per cycle, for divide and remainder.
`default_nettype none
module rpn_divider (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    frac_i,   // fixed-point divide: 96-bit dividend
  input  wire logic [rpn_pkg::ValW-1:0] n_i,     // magnitudes
  input  wire logic [rpn_pkg::ValW-1:0] d_i,
  output logic                         done_o,
  output logic [rpn_pkg::ValW-1:0]     q_o,
  output logic [rpn_pkg::ValW-1:0]     r_o,
  output logic                         over_o
);
  import rpn_pkg::*;

  logic [ValW+31:0] num_q;
  logic [ValW-1:0]  d_q, rem_q, q_q;
  logic [6:0]       cnt_q;
  logic             busy_q, over_q;
  logic [ValW:0]    shifted;
  logic             ge;
  logic [ValW-1:0]  rem_d;

  assign shifted = {rem_q, num_q[ValW+31]};
  assign ge      = (shifted >= {1'b0, d_q});
  assign rem_d   = ge ? ValW'(shifted - {1'b0, d_q}) : shifted[ValW-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= frac_i ? {n_i, 32'd0} : {n_i, 32'd0} >> 0;
      d_q   <= d_i;
      rem_q <= '0;
      q_q   <= '0;
      over_q <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[ValW+30:0], 1'b0};
      rem_q  <= rem_d;
      if (q_q[ValW-1]) over_q <= 1'b1;
      q_q    <= {q_q[ValW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= frac_i ? 7'd95 : 7'd63;
      end else if (busy_q) begin
        if (cnt_q == 7'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

  assign q_o    = q_q;
  assign r_o    = rem_q;
  assign over_o = over_q;
endmodule
`default_nettype wire

>>> sv/rpn_back.sv
// Execution engine: value stack, arithmetic and the result register.
`default_nettype none
module rpn_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tok_valid_i,
  input  wire rpn_pkg::token_t   tok_i,
  output logic                   tok_take_o,
  output logic                   res_valid_o,
  output rpn_pkg::result_t       res_o,
  input  wire logic              res_take_i
);
  import rpn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDB, S_WAITB, S_RDA, S_WAITA, S_MUL1, S_MUL2, S_DIVW, S_PUSH, S_OUT
  } state_e;

  logic [ValW-1:0] stk_q [StackDepth];
  logic [ValW-1:0] rd_data_q;
  logic [PtrW-1:0] sp_q;
  state_e          state_q;
  func_e           func_q;
  logic [ValW-1:0] a_q, b_q, val_q;
  logic            emp_q, full_q, zdiv_q;
  logic [ValW-1:0] ll_q, lh_q, hl_q, hh_q;
  logic            neg_q;
  logic            rd_en;
  logic [AddrW-1:0] rd_addr;
  logic            wr_en;
  result_t         res_q;
  logic            res_valid_q;
  logic            res_load;

  logic            div_start, div_done, div_over;
  logic [ValW-1:0] div_q, div_r;

  function automatic logic [ValW-1:0] mag(input logic [ValW-1:0] v);
    mag = v[ValW-1] ? ValW'(0 - v) : v;
  endfunction

  function automatic logic [ValW-1:0] ssat(input logic neg, input logic [ValW-1:0] m,
                                          input logic over);
    if (neg) ssat = (over || m > MinRaw) ? MinRaw : ValW'(0 - m);
    else     ssat = (over || m > MaxRaw) ? MaxRaw : m;
  endfunction

  // Combinational helpers for the back end.
  logic [ValW-1:0] sum, dif, add_r, sub_r;
  logic [ValW+63:0] mid, lo, hi;
  logic [ValW-1:0] mul_r;
  assign sum   = a_q + b_q;
  assign dif   = a_q - b_q;
  assign add_r = (a_q[ValW-1] == b_q[ValW-1] && sum[ValW-1] != a_q[ValW-1]) ?
                 (a_q[ValW-1] ? MinRaw : MaxRaw) : sum;
  assign sub_r = (a_q[ValW-1] != b_q[ValW-1] && dif[ValW-1] != a_q[ValW-1]) ?
                 (a_q[ValW-1] ? MinRaw : MaxRaw) : dif;
  assign mid   = 128'(ll_q[63:32]) + 128'(lh_q[31:0]) + 128'(hl_q[31:0]);
  assign hi    = 128'(hh_q) + 128'(lh_q[63:32]) + 128'(hl_q[63:32]) + (mid >> 32);
  assign lo    = 128'({mid[31:0], ll_q[31:0]});
  assign mul_r = ssat(neg_q, {hi[31:0], lo[63:32]}, hi[63:32] != 32'd0);

  logic start_div_q;

  rpn_divider u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .frac_i  (func_q == FN_DIV),
    .n_i     (mag(a_q)),
    .d_i     (mag(b_q)),
    .done_o  (div_done),
    .q_o     (div_q),
    .r_o     (div_r),
    .over_o  (div_over)
  );

  assign rd_en   = (state_q == S_RDB || state_q == S_RDA) && sp_q != '0;
  assign rd_addr = AddrW'(sp_q - PtrW'(1));
  assign wr_en   = (state_q == S_PUSH) && sp_q != PtrW'(StackDepth);
  assign tok_take_o = (state_q == S_IDLE) && tok_valid_i;
  // The divider loads in the cycle after the second operand is registered.
  assign div_start  = start_div_q;
  assign res_load   = (state_q == S_OUT) && (!res_valid_q || res_take_i);

  // Stack memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) stk_q[sp_q[AddrW-1:0]] <= val_q;
    if (rd_en) rd_data_q <= stk_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    ll_q <= 64'(a_q[31:0]) * 64'(b_q[31:0]);
    lh_q <= 64'(a_q[31:0]) * 64'(b_q[63:32]);
    hl_q <= 64'(a_q[63:32]) * 64'(b_q[31:0]);
    hh_q <= 64'(a_q[63:32]) * 64'(b_q[63:32]);
  end

  logic rd_hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      res_valid_q <= 1'b0;
      rd_hit_q    <= 1'b0;
      start_div_q <= 1'b0;
      func_q      <= FN_PUSH;
      val_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      emp_q       <= 1'b0;
      full_q      <= 1'b0;
      zdiv_q      <= 1'b0;
      neg_q       <= 1'b0;
      res_q       <= '0;
    end else begin
      start_div_q <= 1'b0;
      if (res_load) res_valid_q <= 1'b1;
      else if (res_take_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (tok_valid_i) begin
            func_q <= tok_i.func;
            val_q  <= tok_i.operand;
            emp_q  <= 1'b0; full_q <= 1'b0; zdiv_q <= 1'b0;
            a_q    <= '0; b_q <= '0;
            priority case (tok_i.func)
              FN_PUSH: state_q <= S_PUSH;
              FN_UNK:  state_q <= S_OUT;
              default: state_q <= S_RDB;
            endcase
          end
        end
        S_RDB, S_RDA: begin
          rd_hit_q <= (sp_q != '0);
          if (sp_q != '0) sp_q <= sp_q - PtrW'(1);
          else emp_q <= 1'b1;
          state_q <= (state_q == S_RDB) ? S_WAITB : S_WAITA;
        end
        S_WAITB: begin
          b_q <= rd_hit_q ? rd_data_q : '0;
          if (func_q == FN_PRT) begin
            val_q   <= rd_hit_q ? rd_data_q : '0;
            state_q <= S_OUT;
          end else if (func_q == FN_DIV && !(rd_hit_q && rd_data_q != '0)) begin
            zdiv_q  <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_RDA;
          end
        end
        S_WAITA: begin
          a_q <= rd_hit_q ? rd_data_q : '0;
          priority case (func_q)
            FN_ADD, FN_SUB, FN_MUL: state_q <= S_MUL1;
            default: begin
              if (b_q == '0) begin
                zdiv_q  <= 1'b1;
                state_q <= S_OUT;
              end else begin
                start_div_q <= 1'b1;
                state_q     <= S_DIVW;
              end
            end
          endcase
        end
        S_MUL1: begin
          // Operand magnitudes go into the multiplier registers next cycle.
          neg_q <= a_q[ValW-1] ^ b_q[ValW-1];
          if (func_q == FN_MUL) begin
            a_q <= mag(a_q); b_q <= mag(b_q);
            state_q <= S_MUL2;
          end else begin
            val_q   <= (func_q == FN_ADD) ? add_r : sub_r;
            state_q <= S_PUSH;
          end
        end
        S_MUL2: begin
          // Partial products are registered this cycle; next cycle combine.
          func_q  <= FN_MUL;
          state_q <= S_DIVW;
          neg_q   <= neg_q;
          val_q   <= '0;
          rd_hit_q <= 1'b1;
        end
        S_DIVW: begin
          if (func_q == FN_MUL) begin
            val_q   <= mul_r;
            state_q <= S_PUSH;
          end else if (div_done) begin
            if (func_q == FN_DIV)
              val_q <= ssat(a_q[ValW-1] ^ b_q[ValW-1], div_q, div_over);
            else
              val_q <= a_q[ValW-1] ? ValW'(0 - div_r) : div_r;
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (sp_q != PtrW'(StackDepth)) sp_q <= sp_q + PtrW'(1);
          else full_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (res_load) begin
            res_q.printed_value   <= (func_q == FN_PRT) ? val_q : '0;
            res_q.printed_valid   <= (func_q == FN_PRT);
            res_q.zero_divisor    <= zdiv_q;
            res_q.stack_empty     <= emp_q;
            res_q.stack_full      <= full_q;
            res_q.unknown_command <= (func_q == FN_UNK);
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule
`default_nettype wire
